@@ rtl/page_allocator_refcount_defines.svh @@
// Assertion macros for the port-level checker of the page allocator.
// No dependencies; included by bare file name.
`ifndef PAGE_ALLOCATOR_REFCOUNT_DEFINES_SVH
`define PAGE_ALLOCATOR_REFCOUNT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/pgalloc_pkg.sv @@
// Shared types and codes for the page allocator.
// No dependencies; imported by every module of the block.
package pgalloc_pkg;

   // request operation codes
   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_FREE   = 2'd1;
   localparam logic [1:0] OP_INCREF = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   // response status codes
   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_NO_PAGE  = 3'd1;
   localparam logic [2:0] ST_BAD_ADDR = 3'd2;
   localparam logic [2:0] ST_IN_USE   = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   // configuration register indexes
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 21;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_PAGE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_PAGE = 1'b1;

   localparam int BASE_W   = 20;
   localparam int LIMIT_W  = 21;
   localparam int SHOWN_W  = 16;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'd4096;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] page_addr;
   } alloc_req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [31:0]        alloc_addr;
      logic [SHOWN_W-1:0] ref_count;
   } alloc_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic clear;
      logic accept;
      logic exec;
   } pgalloc_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
   } pgalloc_stat_type;

endpackage

@@ rtl/page_allocator_refcount.sv @@
// Top level of the page allocator with reference counts.
// Depends on pgalloc_pkg, pgalloc_ctrl and pgalloc_dp.

// Physical page allocator with a free stack and one reference count per
// page. A request (alloc, free/decref, incref, query) is taken when start
// is high and busy is low. Its response is registered in the execute state
// that follows the accept, put on rsp_item and flagged by rsp_valid for
// exactly one cycle.
// There is no back-pressure on the response side: the receiver must take
// rsp_item in the cycle rsp_valid is high. Each request passes through an
// accept cycle, which issues the registered reads of the count memory and
// the free stack, and an execute cycle, which does the read-modify-write
// of the count and the stack push or pop and registers the response; busy
// drops in the cycle rsp_valid is shown, so a new request can be taken
// while a response is shown but not while one executes. After reset, the
// count memory is cleared one entry per cycle, with busy held high; csr
// writes are taken at any time (csr_ready is tied high) but are only to be
// made while no request is in flight. Free, incref and query check page
// alignment and that the page lies in [base_page, limit_page) and within
// NUM_PAGES of base_page; a failed check returns bad address and changes
// nothing.
module page_allocator_refcount
   import pgalloc_pkg::*;
#(
   parameter int NUM_PAGES  = 4096,
   parameter int COUNT_BITS = 16,
   parameter int PAGE_SHIFT = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  alloc_req_type         req_item,
   // response channel
   output logic                  rsp_valid,
   output alloc_rsp_type         rsp_item,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   pgalloc_cmd_type  cmd;
   pgalloc_stat_type stat;

   // config registers never stall
   assign csr_ready = 1'b1;

   pgalloc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   pgalloc_dp #(
      .NUM_PAGES  (NUM_PAGES),
      .COUNT_BITS (COUNT_BITS),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_item  (req_item),
      .rsp_item  (rsp_item),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

@@ rtl/pgalloc_ctrl.sv @@
// Controller FSM of the page allocator: clearing pass, idle, execute.
// Depends on pgalloc_pkg.
module pgalloc_ctrl
   import pgalloc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  pgalloc_stat_type stat,
   output pgalloc_cmd_type  cmd,
   output logic             busy,
   output logic             rsp_valid
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               if (stat.clear_last) begin
                  state_ff <= S_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_EXEC;
                  busy_ff  <= 1'b1;
               end
            end
            S_EXEC: begin
               state_ff     <= S_IDLE;
               busy_ff      <= 1'b0;
               rsp_valid_ff <= 1'b1;
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign cmd.clear  = (state_ff == S_CLEAR);
   assign cmd.accept = start && !busy_ff;
   assign cmd.exec   = (state_ff == S_EXEC);
   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;

endmodule

@@ rtl/pgalloc_dp.sv @@
// Datapath of the page allocator: config registers, address check,
// count memory, free stack and response register. Depends on pgalloc_pkg.
module pgalloc_dp
   import pgalloc_pkg::*;
#(
   parameter int NUM_PAGES  = 4096,
   parameter int COUNT_BITS = 16,
   parameter int PAGE_SHIFT = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pgalloc_cmd_type       cmd,
   output pgalloc_stat_type      stat,
   input  alloc_req_type         req_item,
   output alloc_rsp_type         rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(NUM_PAGES);
   localparam int TOP_W = $clog2(NUM_PAGES + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // config
   logic [BASE_W-1:0]  base_ff;
   logic [LIMIT_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_PAGE:  base_ff  <= csr_wdata[BASE_W-1:0];
            CSR_LIMIT_PAGE: limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // address check on the incoming request
   logic [32:0]      page_ext;
   logic [32:0]      diff;
   logic             addr_ok;
   logic [IDX_W-1:0] in_idx;

   always_comb begin
      page_ext = 33'(req_item.page_addr >> PAGE_SHIFT);
      diff     = page_ext - 33'(base_ff);
      addr_ok  = (req_item.page_addr[PAGE_SHIFT-1:0] == '0)
              && (page_ext >= 33'(base_ff))
              && (page_ext <  33'(limit_ff))
              && (diff     <  33'(NUM_PAGES));
      in_idx   = diff[IDX_W-1:0];
   end

   // request registers
   logic [1:0]       op_ff;
   logic             ok_ff;
   logic [IDX_W-1:0] idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_item.req_type;
         ok_ff  <= addr_ok;
         idx_ff <= in_idx;
      end
   end

   // clearing pass
   logic [IDX_W-1:0] clear_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clear_cnt_ff <= clear_cnt_ff + IDX_W'(1);
      end
   end

   assign stat.clear_last = (clear_cnt_ff == IDX_W'(NUM_PAGES - 1));

   // memories
   logic [COUNT_BITS-1:0] count_mem [NUM_PAGES];
   logic [IDX_W-1:0]      stack_mem [NUM_PAGES];
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [IDX_W-1:0]      stk_rd_ff;
   logic [TOP_W-1:0]      top_ff;
   logic [IDX_W-1:0]      stk_raddr;

   assign stk_raddr = IDX_W'(top_ff - TOP_W'(1));

   // execute-cycle decode
   logic                  cnt_we;
   logic [IDX_W-1:0]      cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic                  push;
   logic [TOP_W-1:0]      top_in;
   logic [COUNT_BITS-1:0] cnt_show;
   logic                  show_en;
   logic [SHOWN_W-1:0]    shown;
   logic [2:0]            status;
   logic [31:0]           alloc_addr;
   logic [LIMIT_W-1:0]    page_sum;
   logic [63:0]           addr_wide;

   always_comb begin
      cnt_we     = 1'b0;
      cnt_waddr  = idx_ff;
      cnt_wdata  = '0;
      push       = 1'b0;
      top_in     = top_ff;
      cnt_show   = '0;
      show_en    = 1'b0;
      status     = ST_DONE;
      alloc_addr = '0;
      page_sum   = LIMIT_W'(base_ff) + LIMIT_W'(stk_rd_ff);
      addr_wide  = 64'(page_sum) << PAGE_SHIFT;
      if (op_ff == OP_ALLOC) begin
         if (top_ff == '0) begin
            status = ST_NO_PAGE;
         end else begin
            top_in     = top_ff - TOP_W'(1);
            cnt_we     = 1'b1;
            cnt_waddr  = stk_rd_ff;
            cnt_wdata  = COUNT_BITS'(1);
            cnt_show   = COUNT_BITS'(1);
            show_en    = 1'b1;
            alloc_addr = addr_wide[31:0];
         end
      end else if (!ok_ff) begin
         status = ST_BAD_ADDR;
      end else begin
         unique case (op_ff)
            OP_FREE: begin
               cnt_we = 1'b1;
               if (cnt_rd_ff > COUNT_BITS'(1)) begin
                  cnt_wdata = cnt_rd_ff - COUNT_BITS'(1);
                  cnt_show  = cnt_wdata;
                  show_en   = 1'b1;
                  status    = ST_IN_USE;
               end else if (top_ff >= TOP_W'(NUM_PAGES)) begin
                  status = ST_FULL;
               end else begin
                  push   = 1'b1;
                  top_in = top_ff + TOP_W'(1);
               end
            end
            OP_INCREF: begin
               cnt_we    = 1'b1;
               cnt_wdata = (cnt_rd_ff < COUNT_MAX) ? cnt_rd_ff + COUNT_BITS'(1)
                                                   : cnt_rd_ff;
               cnt_show  = cnt_wdata;
               show_en   = 1'b1;
            end
            OP_QUERY: begin
               cnt_show = cnt_rd_ff;
               show_en  = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // saturate the count to the response width
   if (COUNT_BITS > SHOWN_W) begin : g_wide
      assign shown = (|cnt_show[COUNT_BITS-1:SHOWN_W]) ? '1 : cnt_show[SHOWN_W-1:0];
   end else begin : g_narrow
      assign shown = SHOWN_W'(cnt_show);
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         count_mem[clear_cnt_ff] <= '0;
      end else if (cmd.exec && cnt_we) begin
         count_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cmd.accept) begin
         cnt_rd_ff <= count_mem[in_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && push) begin
         stack_mem[top_ff[IDX_W-1:0]] <= idx_ff;
      end
      if (cmd.accept) begin
         stk_rd_ff <= stack_mem[stk_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
      end else if (cmd.exec) begin
         top_ff <= top_in;
      end
   end

   // response register
   alloc_rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff.status     <= status;
         rsp_ff.alloc_addr <= alloc_addr;
         rsp_ff.ref_count  <= show_en ? shown : '0;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

@@ rtl/pgalloc_checker.sv @@
// Port-level checker for the page allocator, bound to the top level.
// Depends on pgalloc_pkg and page_allocator_refcount_defines.svh.
`include "page_allocator_refcount_defines.svh"

module pgalloc_checker
   import pgalloc_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          start,
   input logic          busy,
   input logic          rsp_valid,
   input alloc_rsp_type rsp_item
);

   `PA_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "response held over")
   `PA_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid, "accept not busy")
   `PA_ASSERT_IMP(a_rsp_latency, clock, reset, rsp_valid, $past(start && !busy, 2), "bad latency")
   `PA_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy, "busy with response")
   `PA_ASSERT_IMP(a_addr_zero, clock, reset, rsp_valid && (rsp_item.status != ST_DONE), rsp_item.alloc_addr == '0, "addr on failure")

endmodule

bind page_allocator_refcount pgalloc_checker u_pgalloc_checker (.*);

@@ tb/sv/page_allocator_refcount_checker.sv @@
// Response checker for the page allocator: keeps its own free stack, page counts and
// window registers, predicts every response and compares it with the block's output.
// Depends on pgalloc_pkg; instantiated by page_allocator_refcount_test.
module page_allocator_refcount_checker
   import pgalloc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  alloc_req_type         req_item,
   input  logic                  rsp_valid,
   input  alloc_rsp_type         rsp_item,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    pending_count,
   output int                    checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAGES    = 4096;
   localparam int OFFSET_W = 12;
   localparam logic [SHOWN_W-1:0] REFS_MAX = '1;

   typedef struct {
      alloc_req_type req;
      alloc_rsp_type rsp;
   } outcome_type;

   logic [BASE_W-1:0]  base_pg;
   logic [LIMIT_W-1:0] limit_pg;
   logic [11:0]        free_pages [PAGES];
   int                 free_depth;
   logic [SHOWN_W-1:0] page_refs [PAGES];
   outcome_type        outcome_q [$];
   int                 n_errors;
   int                 n_checked;

   // aligned, inside [base, limit) and within the count memory's reach
   function automatic bit locate_page(input logic [31:0] addr, output logic [11:0] idx);
      logic [BASE_W-1:0] pg;
      logic [BASE_W-1:0] rel;
      pg  = addr[31:OFFSET_W];
      rel = pg - base_pg;
      idx = rel[11:0];
      if (addr[OFFSET_W-1:0] != '0) return 1'b0;
      if (pg < base_pg || LIMIT_W'(pg) >= limit_pg) return 1'b0;
      return rel < BASE_W'(PAGES);
   endfunction

   function automatic alloc_rsp_type predict_response(input alloc_req_type req);
      alloc_rsp_type     rsp;
      logic [11:0]       idx;
      logic [BASE_W-1:0] pg;
      rsp        = '0;
      rsp.status = ST_DONE;
      if (req.req_type == OP_ALLOC) begin
         if (free_depth == 0) begin
            rsp.status = ST_NO_PAGE;
         end else begin
            free_depth--;
            idx = free_pages[free_depth];
            page_refs[idx] = SHOWN_W'(1);
            pg = base_pg + BASE_W'(idx);   // wraps, as the byte address keeps 32 bits
            rsp.alloc_addr = {pg, 12'h000};
            rsp.ref_count  = SHOWN_W'(1);
         end
      end else if (!locate_page(req.page_addr, idx)) begin
         rsp.status = ST_BAD_ADDR;
      end else if (req.req_type == OP_FREE) begin
         if (page_refs[idx] > SHOWN_W'(1)) begin
            page_refs[idx]--;
            rsp.status    = ST_IN_USE;
            rsp.ref_count = page_refs[idx];
         end else begin
            page_refs[idx] = '0;
            if (free_depth >= PAGES) begin
               rsp.status = ST_FULL;        // page is lost
            end else begin
               free_pages[free_depth] = idx;
               free_depth++;
            end
         end
      end else begin
         if (req.req_type == OP_INCREF && page_refs[idx] != REFS_MAX) page_refs[idx]++;
         rsp.ref_count = page_refs[idx];
      end
      return rsp;
   endfunction

   always @(posedge clock) begin
      outcome_type got;
      if (reset) begin
         base_pg    = '0;
         limit_pg   = LIMIT_RESET;
         free_depth = 0;
         foreach (page_refs[i]) page_refs[i] = '0;
         outcome_q.delete();
         n_errors  = 0;
         n_checked = 0;
      end else begin
         // response leaves before a new request is taken at the same edge
         if (rsp_valid) begin
            if (outcome_q.size() == 0) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("%t: response with no request outstanding: %0d %h %0d",
                           $realtime, rsp_item.status, rsp_item.alloc_addr,
                           rsp_item.ref_count);
            end else begin
               got = outcome_q.pop_front();
               n_checked++;
               if (rsp_item.status !== got.rsp.status ||
                   rsp_item.alloc_addr !== got.rsp.alloc_addr ||
                   rsp_item.ref_count !== got.rsp.ref_count) begin
                  n_errors++;
                  if (n_errors <= 10) begin
                     $write("%t: mismatch, op %0d addr %h: status %0d/%0d",
                            $realtime, got.req.req_type, got.req.page_addr,
                            got.rsp.status, rsp_item.status);
                     $display(" alloc_addr %h/%h ref_count %0d/%0d (exp/got)",
                              got.rsp.alloc_addr, rsp_item.alloc_addr,
                              got.rsp.ref_count, rsp_item.ref_count);
                  end
               end
            end
         end
         if (start && !busy) begin
            got.req = req_item;
            got.rsp = predict_response(req_item);
            outcome_q.push_back(got);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BASE_PAGE) base_pg = csr_wdata[BASE_W-1:0];
            else if (csr_index == CSR_LIMIT_PAGE) limit_pg = csr_wdata[LIMIT_W-1:0];
         end
      end
      error_count   <= n_errors;
      pending_count <= outcome_q.size();
      checked_count <= n_checked;
   end

endmodule

@@ tb/sv/page_allocator_refcount_test.sv @@
// Top of the page allocator testbench: clock, reset, request and register stimulus,
// verdict. Depends on pgalloc_pkg, page_allocator_refcount and the response checker.
module page_allocator_refcount_test;
   timeunit 1ns;
   timeprecision 1ps;
   import pgalloc_pkg::*;

   localparam int PAGES = 4096;

   // all inputs of the block start at known values
   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   alloc_req_type         req_item  = '0;
   logic                  rsp_valid;
   alloc_rsp_type         rsp_item;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_BASE_PAGE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int error_count;
   int pending_count;
   int checked_count;

   // bookkeeping for the summary, and the window the address picker aims at
   int                 op_sent [4];
   int                 csr_writes;
   int                 settings_run;
   logic [BASE_W-1:0]  win_base  = '0;
   logic [LIMIT_W-1:0] win_limit = LIMIT_RESET;

   page_allocator_refcount uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   page_allocator_refcount_checker response_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_item      (rsp_item),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Safety net. The slowest correct run (clearing pass, about 1600 requests
   // with sender gaps, and the drains) ends long before the 4 ms timeout.
   initial begin
      #4ms;
      $display("page_allocator_refcount_test: errors");
      $finish;
   end

   // Holds start high until the request is taken. Start is left high on
   // return, so a request that follows straight away keeps it high without
   // a second assignment in the same step.
   task automatic issue(input logic [1:0] op, input logic [31:0] addr);
      start    <= 1'b1;
      req_item <= alloc_req_type'{req_type: op, page_addr: addr};
      do @(posedge clock); while (busy);
      op_sent[op]++;
   endtask

   // Sender gap; the request lines carry junk while start is low.
   task automatic rest(input int cycles);
      start    <= 1'b0;
      req_item <= alloc_req_type'{req_type: 2'($urandom), page_addr: $urandom};
      repeat (cycles) @(posedge clock);
   endtask

   // Waits until every response predicted so far has come back. The first
   // edge is always waited out, since the checker's count is registered.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Leaves csr_valid high; set_window lowers it once after the last write.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
   endtask

   // Registers are only touched with the block idle.
   task automatic set_window(input logic [BASE_W-1:0] b, input logic [LIMIT_W-1:0] l);
      drain();
      write_csr(CSR_BASE_PAGE, CSR_DATA_W'(b));
      write_csr(CSR_LIMIT_PAGE, CSR_DATA_W'(l));
      csr_valid <= 1'b0;
      win_base  = b;
      win_limit = l;
      settings_run++;
   endtask

   function automatic logic [1:0] pick_op();
      int roll;
      roll = $urandom_range(99);
      if (roll < 30) return OP_ALLOC;
      if (roll < 60) return OP_FREE;
      if (roll < 85) return OP_INCREF;
      return OP_QUERY;
   endfunction

   // Mostly aligned pages just above base, so counts climb and fall on a few
   // pages; then the window edges, misaligned addresses and plain noise.
   function automatic logic [31:0] pick_addr(input int span);
      logic [LIMIT_W-1:0] pg;
      int                 roll;
      roll = $urandom_range(99);
      pg   = LIMIT_W'(win_base) + LIMIT_W'($urandom_range(span - 1));
      if (roll >= 70 && roll < 80) begin
         case ($urandom_range(5))
            0:       pg = LIMIT_W'(win_base) - LIMIT_W'(1);
            1:       pg = LIMIT_W'(win_base);
            2:       pg = win_limit - LIMIT_W'(1);
            3:       pg = win_limit;
            4:       pg = LIMIT_W'(win_base) + LIMIT_W'(PAGES - 1);
            default: pg = LIMIT_W'(win_base) + LIMIT_W'(PAGES);
         endcase
      end
      if (roll >= 90) return $urandom;
      if (roll >= 80) return {pg[19:0], 12'($urandom_range(1, 4095))};
      return {pg[19:0], 12'h000};
   endfunction

   task automatic run_random(input int n, input int span, input int idle_pct);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < idle_pct) rest($urandom_range(1, 4));
         issue(pick_op(), pick_addr(span));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: the block sits in its clearing pass for a while after reset,
      // issue() simply waits on busy.
      set_window('0, LIMIT_RESET);
      issue(OP_ALLOC, 32'h0000_0000);    // empty stack: no free page
      issue(OP_QUERY, 32'h0000_0000);
      issue(OP_FREE, 32'h0000_0000);     // count already zero: pushed anyway
      issue(OP_FREE, 32'h0000_1000);
      issue(OP_FREE, 32'h0000_1000);     // double free, page 1 stacked twice
      issue(OP_ALLOC, 32'hFFFF_FFFF);    // address ignored on alloc
      issue(OP_INCREF, 32'h0000_1000);
      issue(OP_FREE, 32'h0000_1000);     // still referenced
      issue(OP_FREE, 32'h0000_1000);
      issue(OP_FREE, 32'h0000_1001);     // misaligned
      issue(OP_QUERY, 32'h0000_0FFF);
      issue(OP_QUERY, 32'h00FF_F000);    // last page below limit
      issue(OP_QUERY, 32'h0100_0000);    // page equal to limit
      issue(OP_QUERY, 32'hFFFF_FFFF);
      issue(OP_INCREF, 32'hFFFF_F000);
      repeat (4) issue(OP_ALLOC, 32'h0000_0000);   // drains the stack, last one fails

      // Base moved: push a page with a low base, pop it with the top base so
      // the page number wraps out of the 32-bit byte address.
      set_window(20'hFFF00, 21'h100000);
      issue(OP_FREE, 32'hFFFF_0000);
      set_window(20'hFFFFF, 21'h100000);
      issue(OP_ALLOC, 32'h0000_0000);
      issue(OP_QUERY, 32'hFFFF_F000);
      set_window(20'hFFFFF, 21'h000000);
      issue(OP_QUERY, 32'hFFFF_F000);    // empty window: always a bad address

      // Random phases over a spread of windows and sender idling.
      set_window('0, LIMIT_RESET);
      run_random(300, 8, 0);
      set_window(20'h00100, 21'h00140);
      run_random(300, 80, 67);
      set_window(20'hFFFFF, 21'h100000);
      run_random(200, 2, 17);
      set_window(20'h12345, 21'h13700);  // limit beyond base plus page count
      run_random(200, 16, 0);
      set_window('0, '0);
      run_random(100, 4, 67);
      set_window(20'h40000, 21'h40010);
      run_random(250, 16, 17);

      // Back to the reset window for a last mixed phase.
      set_window('0, LIMIT_RESET);
      run_random(250, 8, 17);

      drain();
      repeat (8) @(posedge clock);

      $display("covered %0d alloc, %0d free, %0d incref, %0d query requests",
               op_sent[OP_ALLOC], op_sent[OP_FREE], op_sent[OP_INCREF], op_sent[OP_QUERY]);
      $display("%0d responses compared over %0d windows (%0d writes), incl. a wrapped base",
               checked_count, settings_run, csr_writes);
      if (error_count == 0 && pending_count == 0)
         $display("page_allocator_refcount_test: clean");
      else
         $display("page_allocator_refcount_test: errors");
      $finish;
   end

endmodule

@@ page_allocator_refcount.f @@
+incdir+rtl
rtl/pgalloc_pkg.sv
rtl/pgalloc_ctrl.sv
rtl/pgalloc_dp.sv
rtl/page_allocator_refcount.sv
rtl/pgalloc_checker.sv
tb/sv/page_allocator_refcount_checker.sv
tb/sv/page_allocator_refcount_test.sv
